>>> hdl/multi_voice_sample_mixer_assert.svh
// Assertion macros for the voice mixer; clocked on clk, disabled in reset.
`ifndef MULTI_VOICE_SAMPLE_MIXER_ASSERT_SVH
`define MULTI_VOICE_SAMPLE_MIXER_ASSERT_SVH
`ifndef SYNTHESIS
`define MVSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MVSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MVSM_ASSERT_NOW(label, ante, cons, msg)
`define MVSM_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> hdl/mvsm_pkg.sv
`default_nettype none
package mvsm_pkg;

    localparam int VOICES        = 16;
    localparam int SAMPLE_FRAMES = 65536;
    localparam int SAMPLE_W      = 16;
    localparam int POS_W         = 17;
    localparam int ADDR_W        = $clog2(SAMPLE_FRAMES);
    localparam int VOICE_W       = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SUM_W         = SAMPLE_W + $clog2(VOICES) + 1;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_PLAY = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    typedef struct packed {
        logic               load;
        logic               play;
        logic               clear;
        logic               visit;
        logic               emit;
        logic [VOICE_W-1:0] voice;
    } mvsm_cmd_t;

    typedef struct packed {
        logic out_busy;
    } mvsm_status_t;

endpackage
`default_nettype wire

>>> hdl/mvsm_ctrl.sv
`default_nettype none
module mvsm_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            op,
    input  wire mvsm_pkg::mvsm_status_t status,
    output mvsm_pkg::mvsm_cmd_t        cmd
);
    import mvsm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [VOICE_W-1:0] voice_reg;
    logic [VOICE_W-1:0] voice_next;
    logic               accept;
    logic               last_voice;

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign last_voice = (voice_reg == VOICE_W'(VOICES - 1));

    always_comb
    begin
        cmd        = '0;
        cmd.voice  = voice_reg;
        state_next = state_reg;
        voice_next = voice_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_LOAD: cmd.load = 1'b1;
                        OP_PLAY: cmd.play = 1'b1;
                        OP_TICK:
                        begin
                            cmd.clear  = 1'b1;
                            voice_next = '0;
                            state_next = S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.visit = 1'b1;
                if (last_voice)
                    state_next = S_DRAIN;
                else
                    voice_next = voice_reg + 1'b1;
            end
            S_DRAIN:
                state_next = S_DONE;
            S_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            voice_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            voice_reg <= voice_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/mvsm_datapath.sv
`default_nettype none
module mvsm_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mvsm_pkg::mvsm_cmd_t   cmd,
    output mvsm_pkg::mvsm_status_t     status,
    input  wire logic [15:0]           address,
    input  wire logic [16:0]           length,
    input  wire logic signed [15:0]    left_in,
    input  wire logic signed [15:0]    right_in,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [15:0]         left_out,
    output logic signed [15:0]         right_out
);
    import mvsm_pkg::*;

    localparam logic [POS_W-1:0] MAX_LENGTH = POS_W'(65536);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-32768);
    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(32767);

    logic [31:0]             sample_mem [SAMPLE_FRAMES];
    logic [31:0]             rdata_reg;

    logic [VOICES-1:0]       active_reg;
    logic [VOICES-1:0]       active_next;
    logic [POS_W-1:0]        pos_reg [VOICES];
    logic [POS_W-1:0]        end_reg [VOICES];

    logic                    acc_en_reg;
    logic                    acc_en_next;
    logic signed [SUM_W-1:0] lsum_reg;
    logic signed [SUM_W-1:0] rsum_reg;
    logic                    out_valid_reg;
    logic signed [15:0]      left_reg;
    logic signed [15:0]      right_reg;

    logic                    free_found;
    logic [VOICE_W-1:0]      free_idx;
    logic [POS_W-1:0]        len_sat;
    logic [POS_W-1:0]        play_end;
    logic [POS_W-1:0]        cur_pos;
    logic [POS_W-1:0]        cur_end;
    logic                    cur_active;
    logic                    cur_live;
    logic [20:0]             load_wide;
    logic [20:0]             pos_wide;
    logic [ADDR_W-1:0]       load_idx;
    logic [ADDR_W-1:0]       read_idx;

    function automatic logic signed [15:0] sat16(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] t;
        t = s;
        if (t < SUM_MIN)
            t = SUM_MIN;
        if (t > SUM_MAX)
            t = SUM_MAX;
        return t[15:0];
    endfunction

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = VOICES - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = VOICE_W'(i);
            end
        end
    end

    assign len_sat    = (length > MAX_LENGTH) ? MAX_LENGTH : length;
    assign play_end   = POS_W'(address) + len_sat;
    assign cur_pos    = pos_reg[cmd.voice];
    assign cur_end    = end_reg[cmd.voice];
    assign cur_active = active_reg[cmd.voice];
    assign cur_live   = (cur_pos < cur_end);
    assign load_wide  = 21'(address);
    assign pos_wide   = 21'(cur_pos);
    assign load_idx   = load_wide[ADDR_W-1:0];
    assign read_idx   = pos_wide[ADDR_W-1:0];

    always_comb
    begin
        active_next = active_reg;
        acc_en_next = 1'b0;
        if (cmd.play && free_found)
            active_next[free_idx] = 1'b1;
        if (cmd.visit && cur_active)
        begin
            if (cur_live)
                acc_en_next = 1'b1;
            else
                active_next[cmd.voice] = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            sample_mem[load_idx] <= {right_in, left_in};
        if (cmd.visit)
            rdata_reg <= sample_mem[read_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.play && free_found)
        begin
            pos_reg[free_idx] <= POS_W'(address);
            end_reg[free_idx] <= play_end;
        end
        else if (cmd.visit && cur_active && cur_live)
            pos_reg[cmd.voice] <= cur_pos + 1'b1;
        if (cmd.emit)
        begin
            left_reg  <= sat16(lsum_reg);
            right_reg <= sat16(rsum_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            acc_en_reg    <= 1'b0;
            lsum_reg      <= '0;
            rsum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            acc_en_reg <= acc_en_next;
            if (cmd.clear)
            begin
                lsum_reg <= '0;
                rsum_reg <= '0;
            end
            else if (acc_en_reg)
            begin
                lsum_reg <= lsum_reg + SUM_W'($signed(rdata_reg[15:0]));
                rsum_reg <= rsum_reg + SUM_W'($signed(rdata_reg[31:16]));
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign left_out        = left_reg;
    assign right_out       = right_reg;

endmodule
`default_nettype wire

>>> hdl/multi_voice_sample_mixer.sv
// Load and play requests are handled on acceptance; the block is ready again the next cycle.
// A tick request clears the sums, walks the voices one memory read per cycle,
// then drains and, once the output is free, puts its frame in the output register.
// The next request is taken while that frame waits; a later tick holds until it is taken.
// Reset (rst_n, asynchronous, active low) frees every voice and empties the output;
// the sample memory is not cleared and holds no defined value until loaded.
`default_nettype none
`include "multi_voice_sample_mixer_assert.svh"
module multi_voice_sample_mixer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         op,
    input  wire logic [15:0]        address,
    input  wire logic [16:0]        length,
    input  wire logic signed [15:0] left_in,
    input  wire logic signed [15:0] right_in,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      left_out,
    output logic signed [15:0]      right_out
);
    import mvsm_pkg::*;

    mvsm_cmd_t    cmd;
    mvsm_status_t status;

    mvsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .status   (status),
        .cmd      (cmd)
    );

    mvsm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .address   (address),
        .length    (length),
        .left_in   (left_in),
        .right_in  (right_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .left_out  (left_out),
        .right_out (right_out)
    );

    `MVSM_ASSERT_NOW(a_emit_free, cmd.emit, !(out_valid && !out_ready), "emit over pending frame")
    `MVSM_ASSERT_NEXT(a_emit_shows, cmd.emit, out_valid, "emitted frame not shown")
    `MVSM_ASSERT_NOW(a_visit_busy, cmd.visit, !in_ready && !cmd.load && !cmd.play, "request during tick")

endmodule
`default_nettype wire
